// ----- design/tile_map_background_pixel_core_assert.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the tile map background pixel core
// All checks are clocked on clk and are disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef TILE_MAP_BACKGROUND_PIXEL_CORE_ASSERT_SVH
`define TILE_MAP_BACKGROUND_PIXEL_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TMBP_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TMBP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/tmbp_pkg.sv -----
// ---------------------------------------------------------------------------
// tmbp_pkg
// Shared types, widths and helper functions of the background pixel core.
// ---------------------------------------------------------------------------
`default_nettype none

package tmbp_pkg;

    localparam int VRAM_ADDR_W = 13;
    localparam int BYTE_W      = 8;
    localparam int COORD_W     = 8;
    localparam int FINE_W      = 3;
    localparam int SHADE_W     = 2;

    // The map covers 32 by 32 bytes starting at 0x1800.
    localparam int MAP_DEPTH = 1024;
    localparam int MAP_AW    = 10;
    localparam logic [2:0] MAP_REGION = 3'b110;

    // Tile data spans 0x1000 to 0x1FFF, split into even and odd byte banks.
    localparam int TILE_BANK_DEPTH = 2048;
    localparam int TILE_AW         = 11;

    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 16;

    typedef enum logic {
        OP_WRITE  = 1'b0,
        OP_RENDER = 1'b1
    } op_t;

    // 85 times a two-bit shade is the shade repeated four times.
    function automatic logic [BYTE_W-1:0] shade_to_grey(input logic [SHADE_W-1:0] shade);
        shade_to_grey = {shade, shade, shade, shade};
    endfunction

    // Bit 7-x of each plane; 7-x on three bits is the inverse of x.
    function automatic logic [SHADE_W-1:0] pick_shade(
        input logic [BYTE_W-1:0] lo_plane,
        input logic [BYTE_W-1:0] hi_plane,
        input logic [FINE_W-1:0] fine_x
    );
        logic [FINE_W-1:0] bit_sel;
        bit_sel    = ~fine_x;
        pick_shade = {hi_plane[bit_sel], lo_plane[bit_sel]};
    endfunction

endpackage

`default_nettype wire

// ----- design/tmbp_ram.sv -----
// ---------------------------------------------------------------------------
// tmbp_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ---------------------------------------------------------------------------
`default_nettype none

module tmbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire                      clk,
    input  wire                      we,
    input  wire  [$clog2(DEPTH)-1:0] waddr,
    input  wire  [WIDTH-1:0]         wdata,
    input  wire                      re,
    input  wire  [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // A read and a write to the same entry in one cycle return the old data.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- design/tile_map_background_pixel_core.sv -----
// ---------------------------------------------------------------------------
// tile_map_background_pixel_core
// Renders background pixels from a tile map held in video memory.
// ---------------------------------------------------------------------------
//  Channel  | Direction | tuser      | tdata (lowest bit up)
//  s_axis   | in        | operation  | address, write_data, pixel_x, pixel_y
//  m_axis   | out       | -          | shade, intensity
//
//  One beat is taken per clock when the output side keeps up.
//  A render beat passes through the map read, the dependent tile row read
//  and the output register before its result is presented on m_axis.
//  A write beat is stored at acceptance and gives no result.
//  Video memory has no reset and no clearing pass; reset clears only the
//  pipeline valid flags.
//  A stall on m_axis holds each stage and its memory read data in place.
// ---------------------------------------------------------------------------
`default_nettype none
`include "tile_map_background_pixel_core_assert.svh"

module tile_map_background_pixel_core
    import tmbp_pkg::*;
(
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    s_axis_tvalid,
    output logic                   s_axis_tready,
    // address[12:0], write_data[20:13], pixel_x[28:21], pixel_y[36:29], zero pad
    input  wire  [IN_TDATA_W-1:0]  s_axis_tdata,
    // operation[0]
    input  wire                    s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  wire                    m_axis_tready,
    // shade[1:0], intensity[9:2], zero pad
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    logic [VRAM_ADDR_W-1:0] in_addr;
    logic [BYTE_W-1:0]      in_wdata;
    logic [COORD_W-1:0]     in_x;
    logic [COORD_W-1:0]     in_y;
    logic                   in_accept;
    logic                   in_render;
    logic                   in_write;

    logic                   map_we;
    logic                   map_re;
    logic [MAP_AW-1:0]      map_raddr;
    logic [BYTE_W-1:0]      map_rdata;

    logic                   lo_we;
    logic                   hi_we;
    logic                   tile_re;
    logic [TILE_AW-1:0]     tile_raddr;
    logic [BYTE_W-1:0]      lo_rdata;
    logic [BYTE_W-1:0]      hi_rdata;

    logic                   s1_valid_reg, s1_valid_next;
    logic [FINE_W-1:0]      s1_x_reg;
    logic [FINE_W-1:0]      s1_y_reg;
    logic                   s2_valid_reg, s2_valid_next;
    logic [FINE_W-1:0]      s2_x_reg;
    logic                   out_valid_reg, out_valid_next;
    logic [SHADE_W-1:0]     out_shade_reg;
    logic [BYTE_W-1:0]      out_grey_reg;
    logic [SHADE_W-1:0]     s2_shade;

    logic                   s1_ready;
    logic                   s2_ready;
    logic                   s1_adv;
    logic                   out_load;

    assign in_addr  = s_axis_tdata[12:0];
    assign in_wdata = s_axis_tdata[20:13];
    assign in_x     = s_axis_tdata[28:21];
    assign in_y     = s_axis_tdata[36:29];

    // Ready chain from the output register back to the input.
    assign s2_ready      = !out_valid_reg || m_axis_tready;
    assign out_load      = s2_valid_reg && s2_ready;
    assign s1_ready      = !s2_valid_reg || s2_ready;
    assign s1_adv        = s1_valid_reg && s1_ready;
    assign s_axis_tready = !s1_valid_reg || s1_ready;

    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign in_render = in_accept && (op_t'(s_axis_tuser) == OP_RENDER);
    assign in_write  = in_accept && (op_t'(s_axis_tuser) == OP_WRITE);

    // Map bytes are also kept in the tile banks, since tile data overlaps the map.
    assign map_we    = in_write && (in_addr[12:10] == MAP_REGION);
    assign map_re    = in_render;
    assign map_raddr = {in_y[7:3], in_x[7:3]};

    assign lo_we      = in_write && in_addr[12] && !in_addr[0];
    assign hi_we      = in_write && in_addr[12] && in_addr[0];
    assign tile_re    = s1_adv;
    assign tile_raddr = {map_rdata, s1_y_reg};

    tmbp_ram #(.WIDTH(BYTE_W), .DEPTH(MAP_DEPTH)) u_map_ram (
        .clk   (clk),
        .we    (map_we),
        .waddr (in_addr[MAP_AW-1:0]),
        .wdata (in_wdata),
        .re    (map_re),
        .raddr (map_raddr),
        .rdata (map_rdata)
    );

    tmbp_ram #(.WIDTH(BYTE_W), .DEPTH(TILE_BANK_DEPTH)) u_lo_ram (
        .clk   (clk),
        .we    (lo_we),
        .waddr (in_addr[TILE_AW:1]),
        .wdata (in_wdata),
        .re    (tile_re),
        .raddr (tile_raddr),
        .rdata (lo_rdata)
    );

    tmbp_ram #(.WIDTH(BYTE_W), .DEPTH(TILE_BANK_DEPTH)) u_hi_ram (
        .clk   (clk),
        .we    (hi_we),
        .waddr (in_addr[TILE_AW:1]),
        .wdata (in_wdata),
        .re    (tile_re),
        .raddr (tile_raddr),
        .rdata (hi_rdata)
    );

    assign s2_shade = pick_shade(lo_rdata, hi_rdata, s2_x_reg);

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (s_axis_tready)
        begin
            s1_valid_next = in_render;
        end
    end

    always_comb
    begin
        s2_valid_next = s2_valid_reg;
        if (s1_ready)
        begin
            s2_valid_next = s1_valid_reg;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s2_ready)
        begin
            out_valid_next = s2_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_render)
        begin
            s1_x_reg <= in_x[2:0];
            s1_y_reg <= in_y[2:0];
        end
        if (s1_adv)
        begin
            s2_x_reg <= s1_x_reg;
        end
        if (out_load)
        begin
            out_shade_reg <= s2_shade;
            out_grey_reg  <= shade_to_grey(s2_shade);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'b000000, out_grey_reg, out_shade_reg};

    `TMBP_ASSERT_NEXT(a_render_enters, in_render, s1_valid_reg,
        "accepted render beat did not enter the map read stage")
    `TMBP_ASSERT_SAME(a_no_accept_on_hold, s1_valid_reg && !s1_ready, !in_accept,
        "input beat accepted while the map read stage was held")
    `TMBP_ASSERT_NEXT(a_hold_keeps_s1, s1_valid_reg && !s1_ready, s1_valid_reg,
        "held render lost from the map read stage")
    `TMBP_ASSERT_NEXT(a_hold_keeps_s2, s2_valid_reg && !s2_ready, s2_valid_reg,
        "held render lost from the tile read stage")

endmodule

`default_nettype wire
